// File: hw/rtl/mipmap_chain_box_downsampler_defines.svh
`ifndef MIPMAP_CHAIN_BOX_DOWNSAMPLER_DEFINES_SVH
`define MIPMAP_CHAIN_BOX_DOWNSAMPLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCBD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcbd check failed");

// next-cycle implication
`define MCBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcbd check failed");

`endif

// File: hw/rtl/mcbd_pkg.sv
`default_nettype none

package mcbd_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int LEVELS_DEF     = 3;
	localparam int MAX_LEVELS     = 3;
	localparam int QUEUE_DEPTH    = 8;

	localparam int PIX_W     = 8;
	localparam int SUM_W     = 9;
	localparam int COORD_W   = 7;
	localparam int LEVEL_W   = 2;
	localparam int DIM_CFG_W = 9;
	localparam int APB_W     = 32;
	localparam int ADDR_W    = 3;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// results gathered for one input pixel, slot i holds mip level i+1
	typedef struct packed {
		logic [LEVEL_W-1:0]                 n;
		logic [MAX_LEVELS-1:0][PIX_W-1:0]   val;
		logic [MAX_LEVELS-1:0][COORD_W-1:0] col;
		logic [MAX_LEVELS-1:0][COORD_W-1:0] row;
	} rec_t;

endpackage

`default_nettype wire

// File: hw/rtl/mcbd_level.sv
`default_nettype none

module mcbd_level import mcbd_pkg::*; #(
	parameter int LEVEL_IDX  = 0,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               item_valid,
	input  logic                               feed,
	input  logic [PIX_W-1:0]                   pix,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]     iw,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]    ih,
	input  rec_t                               rec_in,
	output logic                               item_valid_out,
	output logic                               emit,
	output logic [PIX_W-1:0]                   val,
	output rec_t                               rec_out
);

	localparam int DW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int PAIRS = MAX_WIDTH >> (LEVEL_IDX + 1);
	localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

	logic [SUM_W-1:0] mem [PAIRS];
	logic [SUM_W-1:0] rd_q;

	logic [CW-1:0]    col_q, col_d;
	logic [RW-1:0]    row_q, row_d;
	logic [PIX_W-1:0] held_q;

	logic               item_valid_s1, emit_s1, direct_s1;
	logic [SUM_W-1:0]   hsum_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	rec_t               rec_s1;

	logic             w_one, h_one, col_last, row_last, pair;
	logic             wr_en, rd_en, emit_d, direct_d, hold_en;
	logic [SUM_W-1:0] hsum;
	logic [AW-1:0]    addr;
	logic [SUM_W:0]   vsum;

	always_comb begin
		w_one    = (iw == DW'(1));
		h_one    = (ih == HW'(1));
		col_last = (DW'(col_q) == iw - DW'(1));
		row_last = (HW'(row_q) == ih - HW'(1));
		addr     = AW'(col_q >> 1);
		pair     = 1'b0;
		hsum     = '0;
		hold_en  = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		emit_d   = 1'b0;
		direct_d = 1'b0;
		// a single column is used twice, an odd last column is dropped
		if (w_one) begin
			hsum = {pix, 1'b0};
			pair = 1'b1;
		end else if (!(iw[0] && col_last)) begin
			if (!col_q[0]) begin
				hold_en = 1'b1;
			end else begin
				hsum = SUM_W'(held_q) + SUM_W'(pix);
				pair = 1'b1;
			end
		end
		if (pair) begin
			if (h_one) begin
				emit_d   = 1'b1;
				direct_d = 1'b1;
			end else if (!(ih[0] && row_last)) begin
				if (!row_q[0]) begin
					wr_en = 1'b1;
				end else begin
					rd_en  = 1'b1;
					emit_d = 1'b1;
				end
			end
		end
		hold_en = hold_en && feed;
		wr_en   = wr_en && feed;
		rd_en   = rd_en && feed;
		emit_d  = emit_d && feed;

		col_d = col_q + CW'(1);
		row_d = row_q;
		if (col_last) begin
			col_d = '0;
			row_d = row_last ? '0 : row_q + RW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= item_valid;
			if (clear) begin
				col_q <= '0;
				row_q <= '0;
			end else if (feed) begin
				col_q <= col_d;
				row_q <= row_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_en) begin
			held_q <= pix;
		end
		emit_s1   <= emit_d;
		direct_s1 <= direct_d;
		hsum_s1   <= hsum;
		x_s1      <= COORD_W'(col_q >> 1);
		y_s1      <= COORD_W'(row_q >> 1);
		rec_s1    <= rec_in;
	end

	// upper row pair sums; a write always lands before the lower row reads it
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= hsum;
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	always_comb begin
		vsum           = (SUM_W+1)'(rd_q) + (SUM_W+1)'(hsum_s1);
		val            = direct_s1 ? hsum_s1[SUM_W-1:1] : vsum[SUM_W:2];
		emit           = item_valid_s1 && emit_s1;
		item_valid_out = item_valid_s1;
		rec_out        = rec_s1;
		rec_out.val[LEVEL_IDX] = val;
		rec_out.col[LEVEL_IDX] = x_s1;
		rec_out.row[LEVEL_IDX] = y_s1;
		rec_out.n      = rec_s1.n + LEVEL_W'(emit);
	end

endmodule

`default_nettype wire

// File: hw/rtl/mcbd_result_queue.sv
`default_nettype none

`include "mipmap_chain_box_downsampler_defines.svh"

module mcbd_result_queue import mcbd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rec_t               rec_in,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [LEVEL_W-1:0] level,
	output logic [PIX_W-1:0]   value,
	output logic [COORD_W-1:0] column,
	output logic [COORD_W-1:0] row,
	output logic               last_of_run,
	output logic               pop
);

	localparam int PW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rec_t               q_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [LEVEL_W-1:0] k_q;
	rec_t               head;

	always_comb begin
		head         = q_q[rd_ptr_q];
		result_valid = (count_q != '0);
		level        = k_q + LEVEL_W'(1);
		value        = head.val[k_q];
		column       = head.col[k_q];
		row          = head.row[k_q];
		last_of_run  = (level == head.n);
		pop          = result_valid && result_ready && last_of_run;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= rec_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			k_q      <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			// one beat per result, the record leaves after its last one
			if (result_valid && result_ready) begin
				if (last_of_run) begin
					k_q      <= '0;
					rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
				end else begin
					k_q <= k_q + LEVEL_W'(1);
				end
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	`MCBD_ASSERT_IMP(a_q_no_overflow, push, (count_q != CNT_W'(DEPTH)) || pop)
	`MCBD_ASSERT_IMP(a_q_head_has_result, count_q != '0, (head.n != '0) && (k_q < head.n))
	`MCBD_ASSERT_NEXT(a_q_sub_advance, result_valid && result_ready && !last_of_run, k_q == $past(k_q) + LEVEL_W'(1))

endmodule

`default_nettype wire

// File: hw/rtl/mcbd_cfg.sv
`default_nettype none

module mcbd_cfg import mcbd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int LEVELS     = LEVELS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          psel,
	input  logic                                          penable,
	input  logic                                          pwrite,
	input  logic [ADDR_W-1:0]                             paddr,
	input  logic [APB_W-1:0]                              pwdata,
	output logic [APB_W-1:0]                              prdata,
	output logic                                          pready,
	output logic                                          clear,
	output logic [LEVELS-1:0][$clog2(MAX_WIDTH+1)-1:0]    iw,
	output logic [LEVELS-1:0][$clog2(MAX_HEIGHT+1)-1:0]   ih
);

	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [DIM_CFG_W-1:0] width_q, height_q;
	reg_idx_t             idx;
	logic [31:0]          w32, h32;

	always_comb begin
		idx    = reg_idx_t'(paddr[2]);
		pready = 1'b1;
		clear  = psel && penable && pwrite;
		case (idx)
			REG_WIDTH:  prdata = APB_W'(width_q);
			REG_HEIGHT: prdata = APB_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_CFG_W'(64);
			height_q <= DIM_CFG_W'(64);
		end else if (clear) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[DIM_CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_CFG_W-1:0];
				default:    ;
			endcase
		end
	end

	// level sizes: clamp the base size, then halve with a floor of one
	always_comb begin
		w32 = 32'(width_q);
		h32 = 32'(height_q);
		if (w32 == 32'd0) begin
			w32 = 32'd1;
		end else if (w32 > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end
		if (h32 == 32'd0) begin
			h32 = 32'd1;
		end else if (h32 > 32'(MAX_HEIGHT)) begin
			h32 = 32'(MAX_HEIGHT);
		end
		iw[0] = DW'(w32);
		ih[0] = HW'(h32);
		for (int l = 1; l < LEVELS; l++) begin
			iw[l] = ((iw[l-1] >> 1) == '0) ? DW'(1) : (iw[l-1] >> 1);
			ih[l] = ((ih[l-1] >> 1) == '0) ? HW'(1) : (ih[l-1] >> 1);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mipmap_chain_box_downsampler.sv
`default_nettype none

`include "mipmap_chain_box_downsampler_defines.svh"

// Streams base image pixels in raster order and emits up to LEVELS further mip levels, each
// pixel the truncated mean of a 2x2 block of the level above, as one beat per result with
// level, value, column, row and a flag on the last result of its input pixel. Each level is
// one pipeline stage around its own single-port pair-sum memory, so a pixel is accepted
// every cycle while the result channel keeps up; the result channel moves one beat per
// cycle, and up to QUEUE_DEPTH pixels may be in flight or queued before pixel_ready drops.
// result_valid for the first result of a pixel rises once the pixel has passed the stage
// register of every level and its record is written into the result queue. Memories need
// no clearing pass. A write to image_width or image_height restarts the frame and must be
// made by the user while the block is idle; the block itself does not enforce this.
module mipmap_chain_box_downsampler import mcbd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int LEVELS     = LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  logic [PIX_W-1:0]   pixel,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [LEVEL_W-1:0] level,
	output logic [PIX_W-1:0]   value,
	output logic [COORD_W-1:0] column,
	output logic [COORD_W-1:0] row,
	output logic               last_of_run
);

	localparam int DW      = $clog2(MAX_WIDTH + 1);
	localparam int HW      = $clog2(MAX_HEIGHT + 1);
	localparam int CREDITS = QUEUE_DEPTH;
	localparam int CRW     = $clog2(CREDITS + 1);

	logic                         clear, accept, leave, push, drop, pop;
	logic [LEVELS-1:0][DW-1:0]    iw;
	logic [LEVELS-1:0][HW-1:0]    ih;
	logic [LEVELS-1:0]            lv_valid, lv_emit;
	logic [LEVELS-1:0][PIX_W-1:0] lv_val;
	rec_t                         lv_rec [LEVELS];
	logic [CRW-1:0]               credit_q;

	mcbd_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.LEVELS     (LEVELS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.clear   (clear),
		.iw      (iw),
		.ih      (ih)
	);

	assign pixel_ready = (credit_q < CRW'(CREDITS));
	assign accept      = pixel_valid && pixel_ready;

	for (genvar l = 0; l < LEVELS; l++) begin : g_level
		logic        item_in, feed_in;
		logic [PIX_W-1:0] pix_in;
		rec_t        rec_in;

		if (l == 0) begin : g_first
			assign item_in = accept;
			assign feed_in = accept;
			assign pix_in  = pixel;
			assign rec_in  = '0;
		end else begin : g_next
			// a level sees a pixel only when the level above produced one
			assign item_in = lv_valid[l-1];
			assign feed_in = lv_valid[l-1] && lv_emit[l-1];
			assign pix_in  = lv_val[l-1];
			assign rec_in  = lv_rec[l-1];
		end

		mcbd_level #(
			.LEVEL_IDX  (l),
			.MAX_WIDTH  (MAX_WIDTH),
			.MAX_HEIGHT (MAX_HEIGHT)
		) u_level (
			.clk            (clk),
			.arst_n         (arst_n),
			.clear          (clear),
			.item_valid     (item_in),
			.feed           (feed_in),
			.pix            (pix_in),
			.iw             (iw[l]),
			.ih             (ih[l]),
			.rec_in         (rec_in),
			.item_valid_out (lv_valid[l]),
			.emit           (lv_emit[l]),
			.val            (lv_val[l]),
			.rec_out        (lv_rec[l])
		);
	end

	assign leave = lv_valid[LEVELS-1];
	assign push  = leave && (lv_rec[LEVELS-1].n != '0);
	assign drop  = leave && (lv_rec[LEVELS-1].n == '0);

	mcbd_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.rec_in       (lv_rec[LEVELS-1]),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.level        (level),
		.value        (value),
		.column       (column),
		.row          (row),
		.last_of_run  (last_of_run),
		.pop          (pop)
	);

	// pixels in the pipeline or queued; bounds queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CRW'(accept) - CRW'(pop) - CRW'(drop);
		end
	end

	`MCBD_ASSERT_IMP(a_credit_bound, 1'b1, credit_q <= CRW'(CREDITS))
	`MCBD_ASSERT_IMP(a_result_has_credit, result_valid, credit_q != '0)
	`MCBD_ASSERT_IMP(a_leave_has_credit, leave, credit_q != '0)

endmodule

`default_nettype wire

// File: dv/mipmap_chain_box_downsampler_checker.sv
module mipmap_chain_box_downsampler_checker import mcbd_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [APB_W-1:0]   pwdata,
	input  logic               pixel_valid,
	input  logic               pixel_ready,
	input  logic [PIX_W-1:0]   pixel,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic [LEVEL_W-1:0] level,
	input  logic [PIX_W-1:0]   value,
	input  logic [COORD_W-1:0] column,
	input  logic [COORD_W-1:0] row,
	input  logic               last_of_run,
	output int                 pending_results,
	output int                 mismatch_count
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [PIX_W-1:0]   value;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               last_flag;
	} mip_pixel_t;

	logic [DIM_CFG_W-1:0] width_cfg;
	logic [DIM_CFG_W-1:0] height_cfg;
	logic [SUM_W-1:0]     upper_pair_sum [MAX_LEVELS][MAX_WIDTH_DEF/2];
	logic [PIX_W-1:0]     left_pixel [MAX_LEVELS];
	int unsigned          col_pos [MAX_LEVELS];
	int unsigned          row_pos [MAX_LEVELS];
	mip_pixel_t           mip_expected [$];
	int                   fails;
	int                   beat_count;

	function automatic void restart_frame();
		for (int i = 0; i < MAX_LEVELS; i++) begin
			col_pos[i] = 0;
			row_pos[i] = 0;
		end
	endfunction

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned max_dim);
		if (v < 1)
			return 1;
		if (v > max_dim)
			return max_dim;
		return v;
	endfunction

	// one source pixel into the level below lv, returns 1 when a 2x2 block completes
	function automatic bit step_level(input int lv, input int unsigned src,
			input int unsigned w, input int unsigned h,
			output int unsigned avg, output int unsigned ox, output int unsigned oy);
		int unsigned c;
		int unsigned r;
		int unsigned hsum;
		int unsigned x;
		bit paired;
		bit emit;
		c = col_pos[lv];
		r = row_pos[lv];
		hsum = 0;
		x = 0;
		paired = 1'b0;
		emit = 1'b0;
		avg = 0;
		ox = 0;
		oy = 0;
		if (w == 1) begin
			hsum = 2 * src;
			paired = 1'b1;
		end else if (c < (w / 2) * 2) begin
			if (!c[0]) begin
				left_pixel[lv] = src[PIX_W-1:0];
			end else begin
				hsum = left_pixel[lv] + src;
				x = c >> 1;
				paired = 1'b1;
			end
		end
		if (paired) begin
			if (h == 1) begin
				avg = (2 * hsum) >> 2;
				ox = x;
				emit = 1'b1;
			end else if (r < (h / 2) * 2) begin
				if (!r[0]) begin
					upper_pair_sum[lv][x] = hsum[SUM_W-1:0];
				end else begin
					avg = ((upper_pair_sum[lv][x] + hsum) >> 2) & 32'hFF;
					ox = x;
					oy = r >> 1;
					emit = 1'b1;
				end
			end
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_pos[lv] = c;
		row_pos[lv] = r;
		return emit;
	endfunction

	function automatic void predict_pixel(input logic [PIX_W-1:0] p);
		mip_pixel_t  run [MAX_LEVELS];
		int unsigned w;
		int unsigned h;
		int unsigned src;
		int unsigned avg;
		int unsigned ox;
		int unsigned oy;
		int          n;
		bit          going;
		w = clamp_dim(width_cfg, MAX_WIDTH_DEF);
		h = clamp_dim(height_cfg, MAX_HEIGHT_DEF);
		src = p;
		n = 0;
		going = 1'b1;
		for (int lv = 0; lv < LEVELS && lv < MAX_LEVELS; lv++) begin
			if (going && step_level(lv, src, w, h, avg, ox, oy)) begin
				run[n].level = LEVEL_W'(lv + 1);
				run[n].value = avg[PIX_W-1:0];
				run[n].column = ox[COORD_W-1:0];
				run[n].row = oy[COORD_W-1:0];
				run[n].last_flag = 1'b0;
				n++;
				// a finished pixel feeds the next level straight away
				src = avg;
				w = (w / 2 < 1) ? 1 : w / 2;
				h = (h / 2 < 1) ? 1 : h / 2;
			end else begin
				going = 1'b0;
			end
		end
		if (n > 0)
			run[n-1].last_flag = 1'b1;
		for (int i = 0; i < n; i++)
			mip_expected = {mip_expected, run[i]};
	endfunction

	always @(posedge clk or negedge arst_n) begin : observe
		mip_pixel_t got;
		mip_pixel_t want;
		if (!arst_n) begin
			width_cfg = DIM_CFG_W'(64);
			height_cfg = DIM_CFG_W'(64);
			restart_frame();
			mip_expected.delete();
			fails = 0;
			beat_count = 0;
			pending_results <= 0;
			mismatch_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_WIDTH:  width_cfg = pwdata[DIM_CFG_W-1:0];
					REG_HEIGHT: height_cfg = pwdata[DIM_CFG_W-1:0];
					default:    ;
				endcase
				restart_frame();
			end
			if (result_valid && result_ready) begin
				got = {level, value, column, row, last_of_run};
				if (mip_expected.size() == 0) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("beat %0d: unexpected result level %0d value %0d col %0d row %0d last %0b",
							beat_count, level, value, column, row, last_of_run);
				end else begin
					want = mip_expected.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= REPORT_LIMIT)
							$display("beat %0d: expected level %0d value %0d col %0d row %0d last %0b, %s",
								beat_count, want.level, want.value, want.column, want.row,
								want.last_flag,
								$sformatf("got level %0d value %0d col %0d row %0d last %0b",
									level, value, column, row, last_of_run));
					end
				end
				beat_count++;
			end
			if (pixel_valid && pixel_ready)
				predict_pixel(pixel);
			pending_results <= mip_expected.size();
			mismatch_count <= fails;
		end
	end

endmodule

// File: dv/mipmap_chain_box_downsampler_tb.sv
module mipmap_chain_box_downsampler_tb;
	import mcbd_pkg::*;

	localparam int RANDOM_ITEMS   = 150;
	localparam int EXTREME_ITEMS  = 48;
	localparam int PRESSURE_ITEMS = 40;
	localparam int DRAIN_CYCLES   = 32;
	localparam int HOLD_CYCLES    = 150;
	localparam int CYCLE_LIMIT    = 500000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [APB_W-1:0]   pwdata = '0;
	logic [APB_W-1:0]   prdata;
	logic               pready;
	logic               pixel_valid = 1'b0;
	logic               pixel_ready;
	logic [PIX_W-1:0]   pixel = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [LEVEL_W-1:0] level;
	logic [PIX_W-1:0]   value;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic               last_of_run;
	int                 pending_results;
	int                 mismatch_count;
	logic               sink_idle_en = 1'b0;
	logic               sink_hold = 1'b0;
	bit                 src_idle_en = 1'b0;
	int                 cycle_count = 0;

	mipmap_chain_box_downsampler u_dut (.*);

	mipmap_chain_box_downsampler_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("mipmap_chain_box_downsampler: mismatch");
			$finish;
		end
	end

	// result side: random stall bursts, plus one long hold on request
	initial begin : result_sink
		int unsigned stall;
		bit held;
		stall = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold && !held) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && sink_idle_en && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 9);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic logic [APB_W-1:0] size_word(input int unsigned dim);
		logic [APB_W-1:0] word;
		word = $urandom;
		if ($urandom_range(0, 3) != 0)
			word[APB_W-1:DIM_CFG_W] = '0;
		word[DIM_CFG_W-1:0] = dim[DIM_CFG_W-1:0];
		return word;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// leaves the bus in its access phase so a second write can follow directly
	task automatic write_reg(input reg_idx_t idx, input logic [APB_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		// pixels that make no result may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input int unsigned w, input int unsigned h);
		drain();
		write_reg(REG_WIDTH, size_word(w));
		write_reg(REG_HEIGHT, size_word(h));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] p);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!pixel_ready);
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned w;
		int unsigned h;
		int unsigned n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		src_idle_en = 1'b1;
		sink_idle_en <= 1'b1;

		// partial frame, then a rewrite of the size has to restart it
		set_size(2, 2);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		set_size(2, 2);
		repeat (4) send_pixel(8'hFF);
		// zero sizes clamp to 1x1, so every pixel runs down all levels
		set_size(0, 0);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h5A);
		// odd size: last column and row are dropped
		set_size(3, 3);
		for (int i = 0; i < 9; i++)
			send_pixel(i[0] ? 8'h00 : 8'hFF);
		// single column or row gets used twice
		set_size(1, 2);
		send_pixel(8'hFF);
		send_pixel(8'hFE);
		set_size(2, 1);
		send_pixel(8'h01);
		send_pixel(8'hFF);

		// long result hold while pixels keep coming
		set_size($urandom_range(0, 1), 1);
		src_idle_en = 1'b0;
		sink_hold <= 1'b1;
		repeat (PRESSURE_ITEMS) send_pixel(pick_pixel());

		// widest and tallest frames, register values beyond the maximum clamp
		src_idle_en = 1'b1;
		set_size(511, 1);
		repeat (EXTREME_ITEMS) send_pixel(pick_pixel());
		set_size(1, MAX_HEIGHT_DEF);
		repeat (EXTREME_ITEMS) send_pixel(pick_pixel());

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(0, 511);
				h = $urandom_range(0, 2);
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 12);
			end
			src_idle_en = $urandom_range(0, 3) != 0;
			sink_idle_en <= $urandom_range(0, 3) != 0;
			set_size(w, h);
			n = $urandom_range(4, 40);
			repeat (n) send_pixel(pick_pixel());
			sent += n;
		end

		// closing frames at full rate
		src_idle_en = 1'b0;
		sink_idle_en <= 1'b0;
		w = $urandom_range(2, 4);
		h = $urandom_range(2, 4);
		set_size(w, h);
		repeat (2 * w * h) send_pixel(pick_pixel());
		drain();

		if (mismatch_count == 0 && pending_results == 0)
			$display("mipmap_chain_box_downsampler: match");
		else
			$display("mipmap_chain_box_downsampler: mismatch");
		$finish;
	end

endmodule
